// File: src/shsf_pkg.sv
// Package: constants, operation codes and controller/datapath interface types.
`timescale 1ns / 1ps

package shsf_pkg;

    // Storage and field geometry.
    localparam int SUBGRAPH_DEPTH = 1024;
    localparam int ID_SHIFT       = 11;
    localparam int IDX_W          = $clog2(SUBGRAPH_DEPTH);
    localparam int CNT_W          = $clog2(SUBGRAPH_DEPTH + 1);
    localparam int NODE_W         = 53;
    localparam int CODE_W         = 64;
    localparam int PAY_W          = 64;
    localparam int OP_W           = 2;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = ((NODE_W + CODE_W + PAY_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((CODE_W + PAY_W + 7) / 8) * 8;

    // Operation codes carried on tuser.
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_HIT   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic do_load;   // append node id from the input item
        logic do_clear;  // empty the list and rewind the scan pointer
        logic do_hit;    // capture hit, start read at scan pointer
        logic advance;   // step scan pointer, read next entry
        logic load_out;  // move captured hit into the output register
        logic end_hit;   // hit finished, rewind pointer if batch ended
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ptr_valid; // scan pointer lies inside the stored list
        logic lt;        // stored id below hit node id
        logic eq;        // stored id equals hit node id
        logic out_free;  // output register can take an item this cycle
    } t_status;

endpackage

// File: src/shsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module shsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/shsf_dpath.sv
// Datapath: node list store, count, scan pointer, hit capture and output register.
`timescale 1ns / 1ps

module shsf_dpath
    import shsf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tlast,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic [CODE_W-1:0] r_code;
    logic [PAY_W-1:0]  r_pay;
    logic              r_last;
    logic              r_out_valid, n_out_valid;
    logic [CODE_W-1:0] r_out_code;
    logic [PAY_W-1:0]  r_out_pay;

    logic [CNT_W-1:0]  ptr_inc;
    logic [IDX_W-1:0]  rd_addr;
    logic [NODE_W-1:0] rd_data;
    logic              we;
    logic [CODE_W-1:0] hit_node;
    logic [CODE_W-1:0] stored_node;
    logic              out_free;

    assign ptr_inc = r_ptr + CNT_W'(1);
    assign we      = i_cmd.do_load && (r_count < CNT_W'(SUBGRAPH_DEPTH));
    assign rd_addr = i_cmd.advance ? ptr_inc[IDX_W-1:0] : r_ptr[IDX_W-1:0];

    shsf_ram #(
        .WIDTH (NODE_W),
        .DEPTH (SUBGRAPH_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_s_tdata[NODE_W-1:0]),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Both sides compared at the full code width.
    assign hit_node    = r_code >> ID_SHIFT;
    assign stored_node = {{(CODE_W - NODE_W){1'b0}}, rd_data};
    assign out_free    = !r_out_valid || i_m_tready;

    always_comb begin
        o_status.ptr_valid = r_ptr < r_count;
        o_status.lt        = stored_node < hit_node;
        o_status.eq        = stored_node == hit_node;
        o_status.out_free  = out_free;
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.do_clear) begin
            n_count = '0;
        end else if (we) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.do_clear) begin
            n_ptr = '0;
        end else if (i_cmd.advance) begin
            n_ptr = ptr_inc;
        end else if (i_cmd.end_hit && r_last) begin
            n_ptr = '0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_hit) begin
            r_code <= i_s_tdata[NODE_W +: CODE_W];
            r_pay  <= i_s_tdata[NODE_W + CODE_W +: PAY_W];
            r_last <= i_s_tlast;
        end
        if (i_cmd.load_out) begin
            r_out_code <= r_code;
            r_out_pay  <= r_pay;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'({r_out_pay, r_out_code});

endmodule

// File: src/shsf_ctrl.sv
// Controller: accepts items, sequences the forward scan and issues the result.
`timescale 1ns / 1ps

module shsf_ctrl
    import shsf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic [OP_W-1:0] i_s_tuser,
    output logic            o_s_tready,
    input  t_status         i_status,
    output t_cmd            o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_s_tuser)
                        OP_LOAD:  o_cmd.do_load  = 1'b1;
                        OP_CLEAR: o_cmd.do_clear = 1'b1;
                        OP_HIT: begin
                            o_cmd.do_hit = 1'b1;
                            n_state      = ST_CMP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CMP: begin
                if (!i_status.ptr_valid) begin
                    o_cmd.end_hit = 1'b1;
                    n_state       = ST_IDLE;
                end else if (i_status.lt) begin
                    o_cmd.advance = 1'b1;
                end else if (i_status.eq) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.end_hit = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.end_hit  = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/sorted_hit_subgraph_filter.sv
// Top level: subgraph hit filter over a sorted stream of hits.
`timescale 1ns / 1ps

// Channel   Direction  Contents (lowest bit first)
// s_axis    in         tuser: op; tdata: node_id, hit_code, hit_payload; tlast: batch_last
// m_axis    out        tdata: match_code, match_payload
//
// A load or a clear item is done on acceptance. A hit item steps the scan pointer over
// each stored id below its node, then moves to the output register if it matches; each step is a
// registered read of the node store feeding one 64-bit compare. Items go one at a time.
// Reset (synchronous, active low) empties the list and rewinds the scan pointer; the store
// is not cleared, as only entries below the count are read. A stalled output holds its item
// while the next input item is taken; a second match waits until that register drains.

module sorted_hit_subgraph_filter
    import shsf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // node_id, hit_code, hit_payload, zero pad
    input  logic [OP_W-1:0]      s_axis_tuser,  // op
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // match_code, match_payload
);

    t_cmd    cmd;
    t_status status;

    // The controller decides what each cycle does; the datapath owns all state
    // that the list, the scan and the result need.
    shsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    shsf_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata)
    );

endmodule

// File: dv/tb_sorted_hit_subgraph_filter.sv
// Testbench for the subgraph hit filter: directed cases, full-list loads, stalls, random batches.
`timescale 1ns / 1ps

module tb_sorted_hit_subgraph_filter;
    import shsf_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int RESET_LEN   = 3;
    // A single hit can walk the whole list, so the limit leaves a wide margin.
    localparam int CYCLE_LIMIT = 1000000;
    // Quiet time at the end: longer than any hit walk over a full list.
    localparam int DRAIN_CYCLES = 2 * SUBGRAPH_DEPTH + 32;
    localparam int PAD_W = S_TDATA_W - NODE_W - CODE_W - PAY_W;

    // The fourth op code has no meaning; the block must ignore it.
    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [NODE_W-1:0] NODE_MAX  = '1;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [PAY_W-1:0]  payload;
    } t_match;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // node_id, hit_code, hit_payload, zero pad
    logic [OP_W-1:0]      s_axis_tuser;   // op
    logic                 s_axis_tlast;   // batch_last
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // match_code, match_payload

    sorted_hit_subgraph_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Shadow copy of the subgraph list and the forward scan.
    logic [NODE_W-1:0] list_ids [SUBGRAPH_DEPTH];
    int                list_len;
    int                scan_idx;
    t_match            pending_matches [$];

    int  error_count;
    int  items_sent;
    int  matches_checked;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    int  hold_left;
    bit  hold_pending;

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_matches.size());
            $display("sorted_hit_subgraph_filter regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        error_count++;
        if (error_count <= 40)
            $display("MISMATCH at cycle %0d: %s: got %h, expected %h",
                     cycle_count, what, got_v, want_v);
    endtask

    function automatic logic [NODE_W-1:0] rand_node();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[NODE_W-1:0];
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [CODE_W-1:0] make_hit_code(input logic [NODE_W-1:0] node,
                                                        input logic [ID_SHIFT-1:0] low);
        logic [CODE_W-1:0] c;
        c = CODE_W'(node);
        return (c << ID_SHIFT) | CODE_W'(low);
    endfunction

    // Applies one accepted item to the shadow list and queues the match it causes.
    function automatic void predict_filter(input logic [OP_W-1:0] op,
                                           input logic [NODE_W-1:0] nid,
                                           input logic [CODE_W-1:0] code,
                                           input logic [PAY_W-1:0] payload,
                                           input logic last);
        logic [NODE_W-1:0] node;
        t_match m;
        node = NODE_W'(code >> ID_SHIFT);
        case (op)
            OP_LOAD: begin
                // A full list drops further loads.
                if (list_len < SUBGRAPH_DEPTH) begin
                    list_ids[list_len] = nid;
                    list_len++;
                end
            end
            OP_CLEAR: begin
                list_len = 0;
                scan_idx = 0;
            end
            OP_HIT: begin
                if (scan_idx > list_len)
                    scan_idx = list_len;
                while (scan_idx < list_len && list_ids[scan_idx] < node)
                    scan_idx++;
                if (scan_idx < list_len && list_ids[scan_idx] == node) begin
                    m.code    = code;
                    m.payload = payload;
                    pending_matches.push_back(m);
                end
                if (last)
                    scan_idx = 0;
            end
            default: begin
                // Unused code: nothing changes, batch_last included.
            end
        endcase
    endfunction

    // Inputs are stable at the rising edge, so the accepted item is predicted before
    // any result of the same edge is compared.
    always @(posedge i_clk) begin : check_port
        t_match got;
        t_match want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                predict_filter(s_axis_tuser,
                               s_axis_tdata[NODE_W-1:0],
                               s_axis_tdata[NODE_W+CODE_W-1:NODE_W],
                               s_axis_tdata[NODE_W+CODE_W+PAY_W-1:NODE_W+CODE_W],
                               s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                got.code    = m_axis_tdata[CODE_W-1:0];
                got.payload = m_axis_tdata[CODE_W+PAY_W-1:CODE_W];
                if (pending_matches.size() == 0) begin
                    report_mismatch("result with none expected", got.code, '0);
                end else begin
                    want = pending_matches.pop_front();
                    if (got.code !== want.code)
                        report_mismatch("match_code", got.code, want.code);
                    if (got.payload !== want.payload)
                        report_mismatch("match_payload", got.payload, want.payload);
                end
                matches_checked++;
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_pending) begin
            hold_left    = hold_cycles;
            hold_pending = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] nid,
                             input logic [CODE_W-1:0] code, input logic [PAY_W-1:0] payload,
                             input logic last);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = {{PAD_W{1'b0}}, payload, code, nid};
        s_axis_tuser  = op;
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Withdraws the last item at a falling edge before any wait on rising edges.
    task automatic set_idling(input int send_pct, input int recv_pct);
        @(negedge i_clk);
        s_axis_tvalid  = 1'b0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic wait_for_matches();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_matches.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_hit(input logic [NODE_W-1:0] node, input int unsigned low,
                            input logic last);
        send_item(OP_HIT, rand_node(), make_hit_code(node, ID_SHIFT'(low)), rand_word(), last);
    endtask

    // Empty list, ignored code, repeated nodes, hits behind the pointer, batch ends on
    // the wrong op, an out-of-order load and the field extremes.
    task automatic test_directed_cases();
        set_idling(0, 0);
        send_hit(0, 0, 1'b0);
        send_item(OP_CLEAR, NODE_MAX, '1, '1, 1'b1);
        send_item(OP_UNUSED, NODE_MAX, '1, '1, 1'b0);
        send_item(OP_LOAD, 0, '1, '1, 1'b0);
        send_item(OP_LOAD, 1, '0, '0, 1'b1);
        send_item(OP_LOAD, 5, rand_word(), rand_word(), 1'b0);
        send_item(OP_LOAD, NODE_MAX, rand_word(), rand_word(), 1'b0);
        send_item(OP_HIT, '0, '0, '0, 1'b0);
        // Same node again: the pointer stays on its entry, so this matches too.
        send_item(OP_HIT, NODE_MAX, make_hit_code(0, '1), '1, 1'b0);
        send_hit(1, $urandom, 1'b0);
        send_hit(3, $urandom, 1'b0);
        send_hit(5, $urandom, 1'b0);
        // A batch end on the unused code must not rewind the pointer.
        send_item(OP_UNUSED, rand_node(), make_hit_code(1, 0), rand_word(), 1'b1);
        send_hit(1, $urandom, 1'b0);
        // Nor on a load; this load also breaks the ascending order of the list.
        send_item(OP_LOAD, 7, rand_word(), rand_word(), 1'b1);
        send_hit(1, $urandom, 1'b0);
        send_item(OP_HIT, '0, '1, rand_word(), 1'b1);
        send_hit(1, $urandom, 1'b1);
        // The scan stops at the largest id, which lies before the late load.
        send_hit(7, $urandom, 1'b1);
        send_item(OP_CLEAR, rand_node(), rand_word(), rand_word(), 1'b0);
        send_hit(0, 0, 1'b1);
    endtask

    // Fills the list to capacity, offers two more loads, then hits the far end.
    task automatic test_capacity();
        logic [NODE_W-1:0] node;
        set_idling(0, 0);
        send_item(OP_CLEAR, rand_node(), rand_word(), rand_word(), 1'b0);
        for (int i = 0; i < SUBGRAPH_DEPTH + 2; i++) begin
            node = NODE_W'(3 * i);
            send_item(OP_LOAD, node, rand_word(), rand_word(), rand_bit());
        end
        for (int k = 0; k < 20; k++) begin
            node = NODE_W'(150 * k + $urandom_range(0, 2));
            send_hit(node, $urandom, k == 19);
        end
        send_hit(NODE_W'(3 * (SUBGRAPH_DEPTH - 1)), $urandom, 1'b1);
        send_hit(NODE_W'(3 * SUBGRAPH_DEPTH), $urandom, 1'b1);
        send_hit(0, $urandom, 1'b1);
    endtask

    // A long receiver hold-off while matching hits keep coming, then a full drain.
    task automatic test_output_stall();
        set_idling(0, 0);
        send_item(OP_CLEAR, rand_node(), rand_word(), rand_word(), 1'b0);
        send_item(OP_LOAD, 40, rand_word(), rand_word(), 1'b0);
        send_item(OP_LOAD, 41, rand_word(), rand_word(), 1'b0);
        send_item(OP_LOAD, 42, rand_word(), rand_word(), 1'b0);
        wait_for_matches();
        hold_cycles = 400;
        hold_pending = 1'b1;
        for (int i = 0; i < 24; i++)
            send_hit(NODE_W'(40 + i / 10), $urandom, i == 23);
        wait_for_matches();
        set_idling(0, 30);
        for (int i = 0; i < 8; i++)
            send_hit(41, $urandom, i == 7);
    endtask

    // One clear, a short list and a few sorted batches, with some noise mixed in.
    task automatic traffic_session();
        logic [NODE_W-1:0] ids [32];
        logic [NODE_W-1:0] base;
        logic [NODE_W-1:0] node;
        int len;
        int hits;
        int j;
        int pick;
        send_item(OP_CLEAR, rand_node(), rand_word(), rand_word(), rand_bit());
        len = $urandom_range(1, 24);
        if ($urandom_range(0, 7) == 0) begin
            base = NODE_MAX - NODE_W'(3 * len);
        end else begin
            base = rand_node() >> $urandom_range(0, NODE_W - 1);
            if (base > NODE_MAX - 200)
                base = base - 200;
        end
        ids[0] = base;
        for (int i = 1; i < len; i++)
            ids[i] = ids[i-1] + NODE_W'($urandom_range(0, 3));
        for (int i = 0; i < len; i++)
            send_item(OP_LOAD, ids[i], rand_word(), rand_word(), rand_bit());
        repeat ($urandom_range(1, 4)) begin
            hits = $urandom_range(1, 12);
            j    = 0;
            node = (base >= 2) ? base - 2 : base;
            for (int h = 0; h < hits; h++) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    send_item(OP_UNUSED, rand_node(), rand_word(), rand_word(), rand_bit());
                end else if (pick < 7) begin
                    // Likely behind the pointer.
                    send_hit(ids[$urandom_range(0, len - 1)], $urandom, rand_bit());
                end else if (pick < 9) begin
                    send_item(OP_LOAD, rand_node() >> $urandom_range(0, NODE_W - 1),
                              rand_word(), rand_word(), rand_bit());
                end else if (pick < 11) begin
                    send_item(OP_HIT, rand_node(), rand_word(), rand_word(), rand_bit());
                end else if (pick < 12) begin
                    send_item(OP_CLEAR, rand_node(), rand_word(), rand_word(), rand_bit());
                end else begin
                    if (pick < 70) begin
                        j = j + $urandom_range(0, 1);
                        if (j >= len)
                            j = len - 1;
                        if (ids[j] > node)
                            node = ids[j];
                    end else if (node <= NODE_MAX - 3) begin
                        node = node + NODE_W'($urandom_range(0, 3));
                    end
                    send_hit(node, $urandom, h == hits - 1);
                end
            end
        end
    endtask

    task automatic test_random_traffic(input int target, input int send_pct, input int recv_pct);
        int start;
        set_idling(send_pct, recv_pct);
        start = items_sent;
        while (items_sent - start < target)
            traffic_session();
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_LOAD;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        list_len       = 0;
        scan_idx       = 0;
        error_count    = 0;
        items_sent     = 0;
        matches_checked = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        hold_left      = 0;
        hold_pending   = 1'b0;
        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_capacity();
        test_output_stall();
        test_random_traffic(175, 0, 0);
        test_random_traffic(175, 52, 0);
        test_random_traffic(175, 0, 52);
        test_random_traffic(175, 6, 6);

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        set_idling(0, 0);
        wait_for_matches();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_matches.size() != 0)
            report_mismatch("results never emitted", 64'(pending_matches.size()), 64'(0));
        $display("Covered directed corners, a full list with dropped loads, a long output");
        $display("hold-off and four idling phases: %0d items, %0d results, %0d errors.",
                 items_sent, matches_checked, error_count);
        if (error_count == 0) begin
            $display("sorted_hit_subgraph_filter regression: pass");
        end else begin
            $display("sorted_hit_subgraph_filter regression: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/shsf_pkg.sv
src/shsf_ram.sv
src/shsf_dpath.sv
src/shsf_ctrl.sv
src/sorted_hit_subgraph_filter.sv
dv/tb_sorted_hit_subgraph_filter.sv
